// File: hdl/vdc_pkg.sv
// ----------------------------------------------------------------------------
// vdc_pkg: shared types and constants for the verified digest cache
// Command codes, widths and the record carried along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none
package vdc_pkg;
    localparam int DIGEST_W  = 256;
    localparam int TIME_W    = 32;
    localparam int STAMP_W   = 32;
    localparam int AGE_W     = 16;
    localparam int SLOT_W    = 5;
    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd600;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // one entry of the cache as a cell holds it
    typedef struct packed {
        logic                valid;
        logic [DIGEST_W-1:0] digest;
        logic [TIME_W-1:0]   tstamp;
        logic [STAMP_W-1:0]  stamp;
    } entry_t;
endpackage
`default_nettype wire

// File: hdl/verified_digest_cache_ttl_lru.sv
// ----------------------------------------------------------------------------
// verified_digest_cache_ttl_lru: digest cache with age limit and LRU refill
// Entries sit in a ring of cells; a command walks the ring once to scan and once to update.
// ----------------------------------------------------------------------------
// Each command runs a scan rotation through all ENTRIES cells, then an update
// rotation, then a result state (ST_SCAN, ST_UPD, ST_DONE). A new command is
// taken only from idle; busy stays high through both rotations and the result
// state. Results strobe once, no stall.
// Reset: all entries invalid, stamp counter zero, age limit 600.
`default_nettype none
module verified_digest_cache_ttl_lru #(
    parameter int ENTRIES = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cmd,
    input  wire logic [63:0] digest_w0,
    input  wire logic [63:0] digest_w1,
    input  wire logic [63:0] digest_w2,
    input  wire logic [63:0] digest_w3,
    input  wire logic [31:0] now_seconds,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    output logic             done,
    output logic             hit,
    output logic             expired,
    output logic [4:0]       slot,
    output logic             evicted
);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] idx;
    logic [15:0]  max_age_reg;
    logic [31:0]  recency_reg;
    logic         cmd_reg;
    logic [255:0] dig_reg;
    logic [31:0]  now_reg;
    logic         m_found_reg, f_found_reg;
    logic [IDX_W-1:0] m_idx_reg, f_idx_reg, l_idx_reg, tgt_reg;
    logic [31:0]  l_stamp_reg;
    logic [31:0]  m_time_reg;
    logic         do_write_reg, do_inval_reg, do_touch_reg;
    logic         hit_reg, exp_reg, evi_reg;

    // end-of-scan decision terms
    logic m_fin, f_fin;
    logic [IDX_W-1:0] m_idx_fin, f_idx_fin, l_idx_fin;
    logic [31:0] m_time_fin;
    logic do_write_next, do_touch_next, do_inval_next;
    logic [IDX_W-1:0] tgt_next;
    logic [31:0] age;

    vdc_pkg::entry_t chain [ENTRIES];
    vdc_pkg::entry_t head_in;
    vdc_pkg::entry_t tail;
    logic shift;

    assign idx   = cnt_reg[IDX_W-1:0];
    assign tail  = chain[ENTRIES-1];
    assign shift = (state_reg == ST_SCAN) || (state_reg == ST_UPD);

    // the ring: tail goes to head; the tail holds entry "idx" and feeds cell 0 on each shift
    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                vdc_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                                 .prev_entry(head_in), .entry(chain[g]));
            end
            else
            begin : g_body
                vdc_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                                 .prev_entry(chain[g-1]), .entry(chain[g]));
            end
        end
    endgenerate

    // entry under examination is the one at the tail
    logic match_now;
    assign match_now = tail.valid && (tail.digest == dig_reg);

    // update pass rewrites the target as it passes
    always_comb
    begin
        head_in = tail;
        if (state_reg == ST_UPD && idx == tgt_reg)
        begin
            if (do_write_reg)
            begin
                head_in.valid  = 1'b1;
                head_in.digest = dig_reg;
                head_in.tstamp = now_reg;
                head_in.stamp  = recency_reg;
            end
            else if (do_touch_reg)
            begin
                head_in.stamp = recency_reg;
            end
            else if (do_inval_reg)
            begin
                head_in.valid = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_SCAN;
            ST_SCAN: if (cnt_reg == CNT_W'(ENTRIES - 1)) state_next = ST_UPD;
            ST_UPD:  if (cnt_reg == CNT_W'(ENTRIES - 1)) state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            max_age_reg <= vdc_pkg::MAX_AGE_RESET;
            recency_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                max_age_reg <= cfg_wdata;
            end
            if (shift)
            begin
                cnt_reg <= (cnt_reg == CNT_W'(ENTRIES - 1)) ? '0 : cnt_reg + 1'b1;
            end
            if (state_reg == ST_SCAN && cnt_reg == CNT_W'(ENTRIES - 1))
            begin
                if (do_write_next || do_touch_next)
                begin
                    recency_reg <= recency_reg + 32'd1;
                end
            end
        end
    end

    // decision at end of scan, using the final cycle's entry too
    always_comb
    begin
        m_fin = m_found_reg;
        m_idx_fin = m_idx_reg;
        m_time_fin = m_time_reg;
        f_fin = f_found_reg;
        f_idx_fin = f_idx_reg;
        l_idx_fin = l_idx_reg;
        if (!m_found_reg && match_now)
        begin
            m_fin = 1'b1;
            m_idx_fin = idx;
            m_time_fin = tail.tstamp;
        end
        if (!f_found_reg && !tail.valid)
        begin
            f_fin = 1'b1;
            f_idx_fin = idx;
        end
        if (tail.stamp < l_stamp_reg)
        begin
            l_idx_fin = idx;
        end
        age = now_reg - m_time_fin;
        do_write_next = 1'b0;
        do_touch_next = 1'b0;
        do_inval_next = 1'b0;
        tgt_next = m_idx_fin;
        if (cmd_reg == vdc_pkg::CMD_INSERT)
        begin
            do_write_next = 1'b1;
            tgt_next = m_fin ? m_idx_fin : (f_fin ? f_idx_fin : l_idx_fin);
        end
        else if (m_fin)
        begin
            if (age <= {16'd0, max_age_reg}) do_touch_next = 1'b1;
            else do_inval_next = 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            cmd_reg <= cmd;
            dig_reg <= {digest_w3, digest_w2, digest_w1, digest_w0};
            now_reg <= now_seconds;
            m_found_reg <= 1'b0;
            f_found_reg <= 1'b0;
            m_idx_reg <= '0;
            f_idx_reg <= '0;
            l_idx_reg <= '0;
            l_stamp_reg <= '1;
            m_time_reg <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            m_found_reg <= m_fin;
            m_idx_reg <= m_idx_fin;
            m_time_reg <= m_time_fin;
            f_found_reg <= f_fin;
            f_idx_reg <= f_idx_fin;
            if (idx == '0 || tail.stamp < l_stamp_reg)
            begin
                l_idx_reg <= idx;
                l_stamp_reg <= tail.stamp;
            end
            if (cnt_reg == CNT_W'(ENTRIES - 1))
            begin
                do_write_reg <= do_write_next;
                do_touch_reg <= do_touch_next;
                do_inval_reg <= do_inval_next;
                tgt_reg <= tgt_next;
                hit_reg <= do_touch_next;
                exp_reg <= do_inval_next;
                evi_reg <= (cmd_reg == vdc_pkg::CMD_INSERT) && !m_fin && !f_fin;
            end
        end
    end

    assign busy    = (state_reg != ST_IDLE);
    assign done    = (state_reg == ST_DONE);
    assign hit     = hit_reg;
    assign expired = exp_reg;
    assign evicted = evi_reg;
    assign slot    = (do_write_reg || do_touch_reg || do_inval_reg)
                     ? 5'(tgt_reg) : 5'd0;

    // checks
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && expired)) else $error("hit and expired together");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("busy after result");
endmodule
`default_nettype wire

// File: hdl/vdc_cell.sv
// ----------------------------------------------------------------------------
// vdc_cell: one cache entry in the rotating chain
// Holds an entry and hands it to its neighbour when the chain shifts.
// ----------------------------------------------------------------------------
`default_nettype none
module vdc_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           shift,
    input  wire vdc_pkg::entry_t prev_entry,
    output vdc_pkg::entry_t      entry
);
    logic                entry_valid_reg;
    vdc_pkg::entry_t     entry_data_reg;

    // valid bit is control and resets; payload does not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            entry_valid_reg <= prev_entry.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_data_reg <= prev_entry;
        end
    end

    always_comb
    begin
        entry       = entry_data_reg;
        entry.valid = entry_valid_reg;
    end
endmodule
`default_nettype wire
